// ===== hdl/barometric_sensor_compensation_unit_macros.svh =====
// Assertion macros for the checker module.
// Depends on nothing; included by the checker module.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_UNIT_MACROS_SVH
// Implication under reset
`define BSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication under reset
`define BSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/bsc_pkg.sv =====
// Shared types and constants of the compensation unit.
// No dependencies.
`timescale 1ns / 1ps
package bsc_pkg;
  localparam int unsigned CalW = 48;
  localparam int unsigned RawW = 20;
  localparam logic [1:0] RegTemp = 2'd0;
  localparam logic [1:0] RegPressA = 2'd1;
  localparam logic [1:0] RegPressB = 2'd2;
  localparam logic [1:0] RegPressC = 2'd3;
  localparam logic [19:0] SkipMark = 20'h80000;
  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [63:0] PressBase = 64'd1048576;
  localparam logic [63:0] PressScale = 64'd3125;
  localparam logic [63:0] RoundHalf = 64'd128;
  localparam int unsigned DivSteps = 64;

  typedef struct packed {
    logic [15:0] t1;
    logic signed [15:0] t2, t3;
    logic [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [31:0] centi;
    logic [31:0] press;
    logic invalid;
  } res_t;
endpackage

// ===== hdl/bsc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_div (
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  input  logic [64:0] tag_i,
  output logic signed [63:0] quo_o,
  output logic [64:0] tag_o
);
  localparam int unsigned N = bsc_pkg::DivSteps;
  logic [63:0] rem_q [N+1];
  logic [63:0] quo_q [N+1];
  logic [63:0] den_q [N+1];
  logic        neg_q [N+1];
  logic [64:0] tag_q [N+1];

  // Load magnitudes
  always_comb begin
    rem_q[0] = '0;
    quo_q[0] = num_i[63] ? 64'(-num_i) : num_i;
    den_q[0] = den_i[63] ? 64'(-den_i) : den_i;
    neg_q[0] = num_i[63] ^ den_i[63];
    tag_q[0] = tag_i;
  end

  // One restoring step per stage
  for (genvar s = 0; s < N; s++) begin : g_step
    logic [64:0] trial;
    logic [63:0] sh;
    assign sh = {rem_q[s][62:0], quo_q[s][63]};
    assign trial = {1'b0, sh} - {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= (rem_q[s][63] || !trial[64]) ? trial[63:0] : sh;
        quo_q[s+1] <= {quo_q[s][62:0], (rem_q[s][63] || !trial[64])};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign quo_o = neg_q[N] ? 64'(-quo_q[N]) : quo_q[N];
  assign tag_o = tag_q[N];
endmodule

// ===== hdl/bsc_front.sv =====
// Temperature and pressure pre-divide stages.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_front (
  input  logic clk_i,
  input  logic en_i,
  input  bsc_pkg::cal_t cal_i,
  input  logic [19:0] adc_t_i,
  input  logic [19:0] adc_p_i,
  output logic signed [63:0] num_o,
  output logic signed [63:0] den_o,
  output logic [64:0] tag_o
);
  // stage 1: temperature products
  logic signed [63:0] d1, d2, tv1_q, dd_q;
  logic [19:0] p1a_q;
  assign d1 = 64'(adc_t_i >> 3) - (64'(cal_i.t1) << 1);
  assign d2 = 64'(adc_t_i >> 4) - 64'(cal_i.t1);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tv1_q <= (d1 * 64'(cal_i.t2)) >>> 11;
      dd_q  <= (d2 * d2) >>> 12;
      p1a_q <= adc_p_i;
    end
  end

  // stage 2: fine temperature
  logic signed [31:0] fine_q;
  logic [19:0] p2a_q;
  logic signed [63:0] tv2;
  assign tv2 = (dd_q * 64'(cal_i.t3)) >>> 14;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fine_q <= 32'(tv1_q + tv2);
      p2a_q  <= p1a_q;
    end
  end

  // stage 3: v1 squares; v1 always fits in 33 bits
  logic signed [32:0] v1;
  logic signed [63:0] sq_q, v1_q;
  logic signed [31:0] c_q;
  logic [19:0] p3a_q;
  logic signed [31:0] f3_q;
  assign v1 = 33'(fine_q) - 33'(bsc_pkg::FineOffset);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= v1 * v1;
      v1_q  <= 64'(v1);
      c_q   <= 32'((64'(fine_q) * 5 + bsc_pkg::RoundHalf) >> 8);
      p3a_q <= p2a_q;
      f3_q  <= fine_q;
    end
  end

  // stage 4: calibration products
  logic signed [63:0] a6_q, a5_q, a3_q, a2_q;
  logic signed [31:0] c4_q;
  logic [19:0] p4a_q;
  logic signed [31:0] f4_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a6_q  <= sq_q * 64'(cal_i.p6);
      a5_q  <= (v1_q * 64'(cal_i.p5)) <<< 17;
      a3_q  <= (sq_q * 64'(cal_i.p3)) >>> 8;
      a2_q  <= (v1_q * 64'(cal_i.p2)) <<< 12;
      c4_q  <= c_q;
      p4a_q <= p3a_q;
      f4_q  <= f3_q;
    end
  end

  // stage 5: sums
  logic signed [63:0] var2_q, s1_q;
  logic signed [31:0] c5_q;
  logic [19:0] p5a_q;
  logic signed [31:0] f5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      var2_q <= a6_q + a5_q + (64'(cal_i.p4) <<< 35);
      s1_q   <= (64'sd1 <<< 47) + a3_q + a2_q;
      c5_q   <= c4_q;
      p5a_q  <= p4a_q;
      f5_q   <= f4_q;
    end
  end

  // stage 6: divisor and scaled numerator base
  logic signed [63:0] den_q, nb_q;
  logic signed [31:0] c6_q;
  logic [19:0] p6a_q;
  logic signed [31:0] f6_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= (s1_q * $signed({48'd0, cal_i.p1})) >>> 33;
      nb_q  <= ((bsc_pkg::PressBase - 64'(p5a_q)) << 31) - var2_q;
      c6_q  <= c5_q;
      p6a_q <= p5a_q;
      f6_q  <= f5_q;
    end
  end

  // stage 7: numerator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= nb_q * bsc_pkg::PressScale;
      den_o <= den_q;
      tag_o <= {(p6a_q == bsc_pkg::SkipMark) || (den_q == 64'sd0), f6_q, c6_q};
    end
  end
endmodule

// ===== hdl/bsc_back.sv =====
// Post-divide pressure correction and saturation.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_back (
  input  logic clk_i,
  input  logic en_i,
  input  bsc_pkg::cal_t cal_i,
  input  logic signed [63:0] quo_i,
  input  logic [64:0] tag_i,
  output bsc_pkg::res_t res_o
);
  // stage A: partial products of the scaled quotient square, and the p8 term
  logic signed [63:0] ps, pq_q, p8_q;
  logic [63:0] ll_q;
  logic [31:0] hl_q;
  logic [64:0] t_a_q;
  assign ps = quo_i >>> 13;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q  <= ps[31:0] * ps[31:0];
      hl_q  <= ps[63:32] * ps[31:0];
      pq_q  <= quo_i;
      p8_q  <= (64'(cal_i.p8) * quo_i) >>> 19;
      t_a_q <= tag_i;
    end
  end

  // stage B: assemble the square modulo 2^64, then the p9 term
  logic signed [63:0] psq, pb_q, p9_q, p8b_q;
  logic [64:0] t_b_q;
  assign psq = $signed(ll_q + {hl_q[30:0], 33'd0});
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p9_q  <= (64'(cal_i.p9) * psq) >>> 25;
      pb_q  <= pq_q;
      p8b_q <= p8_q;
      t_b_q <= t_a_q;
    end
  end

  // stage C: final sum and saturation
  logic signed [63:0] p;
  logic [31:0] sat;
  assign p = ((pb_q + p9_q + p8b_q) >>> 8) + (64'(cal_i.p7) <<< 4);
  always_comb begin
    if (p[63]) sat = '0;
    else if (p[62:32] != '0) sat = '1;
    else sat = p[31:0];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.invalid <= t_b_q[64];
      res_o.fine    <= t_b_q[63:32];
      res_o.centi   <= t_b_q[31:0];
      res_o.press   <= t_b_q[64] ? 32'd0 : sat;
    end
  end
endmodule

// ===== hdl/barometric_sensor_compensation_unit.sv =====
// Top level: calibration registers, pipeline control and stream ports.
// Depends on bsc_pkg, bsc_front, bsc_div, bsc_back.
//  channel | dir | word
//  s_axis  | in  | tdata[19:0] raw_temperature, [39:20] raw_pressure
//  m_axis  | out | tdata fine, centi, pressure_q24_8; tuser pressure_invalid
//  cfg     | in  | index 0..3, 48-bit calibration data
// One word a cycle while the output is not held; stages: 7 front, 64 divide, 3 back.
// The 64-step divider sets the depth. The whole pipe stalls as one when
// the output is held; reset clears the valid bits and calibration.
`timescale 1ns / 1ps
module barometric_sensor_compensation_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // raw_temperature, raw_pressure
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [95:0] m_axis_tdata,   // fine_temperature, temperature_centi, pressure_q24_8
  output logic m_axis_tuser,          // pressure_invalid
  input  logic cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  // Valid bits for every stage before the output register
  localparam int unsigned Depth = 7 + bsc_pkg::DivSteps + 2;
  logic [47:0] tc_q, pa_q, pb_q, pc_q;
  bsc_pkg::cal_t cal;
  logic [Depth-1:0] vld_q;
  logic en;
  bsc_pkg::res_t res;
  logic signed [63:0] num, den, quo;
  logic [64:0] tg, tgo;

  // Write calibration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0; pa_q <= '0; pb_q <= '0; pc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bsc_pkg::RegTemp:   tc_q <= cfg_data_i;
        bsc_pkg::RegPressA: pa_q <= cfg_data_i;
        bsc_pkg::RegPressB: pb_q <= cfg_data_i;
        bsc_pkg::RegPressC: pc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cal = {tc_q[15:0], tc_q[31:16], tc_q[47:32], pa_q[15:0], pa_q[31:16],
                pa_q[47:32], pb_q[15:0], pb_q[31:16], pb_q[47:32], pc_q[15:0],
                pc_q[31:16], pc_q[47:32]};

  // Advance whole pipe unless the output word is held
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
      m_axis_tvalid <= vld_q[Depth-1];
    end
  end

  bsc_front u_front (.clk_i, .en_i(en), .cal_i(cal), .adc_t_i(s_axis_tdata[19:0]),
                     .adc_p_i(s_axis_tdata[39:20]), .num_o(num), .den_o(den), .tag_o(tg));
  bsc_div u_div (.clk_i, .en_i(en), .num_i(num),
                 .den_i(den == 64'sd0 ? 64'sd1 : den), .tag_i(tg), .quo_o(quo), .tag_o(tgo));
  bsc_back u_back (.clk_i, .en_i(en), .cal_i(cal), .quo_i(quo), .tag_i(tgo), .res_o(res));

  assign m_axis_tdata = {res.press, res.centi, res.fine};
  assign m_axis_tuser = res.invalid;
endmodule

// ===== hdl/bsc_checker.sv =====
// Port-level checker for the compensation unit, bound to the top level.
// Depends on the macro header.
`timescale 1ns / 1ps
`include "barometric_sensor_compensation_unit_macros.svh"
module bsc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic m_axis_tuser
);
  `BSC_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `BSC_ASSERT_IMP(a_inv0, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[95:64] == 32'd0)
  `BSC_ASSERT_IMP(a_rdy, clk_i, rst_ni, m_axis_tready || !m_axis_tvalid, s_axis_tready)
endmodule

bind barometric_sensor_compensation_unit bsc_checker u_chk (.clk_i, .rst_ni, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser);

// ===== tb/tb_barometric_sensor_compensation_unit.sv =====
// Testbench of the pressure/temperature compensation unit: random stream traffic
// checked word by word against a behavioural predictor. Depends on bsc_pkg and the RTL.
`timescale 1ns / 1ps
module tb_barometric_sensor_compensation_unit;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] centi;
    logic [31:0] press;
    logic        invalid;
  } comp_word_t;

  // Hold calibration and predict one compensated word per raw sample
  class comp_scoreboard;
    logic [47:0] cal [4];
    comp_word_t pending [$];
    int errors;

    function new();
      for (int i = 0; i < 4; i++) cal[i] = '0;
      errors = 0;
    endfunction

    function logic signed [63:0] s16(logic [47:0] r, int pos);
      logic [15:0] f;
      f = r[pos +: 16];
      return {{48{f[15]}}, f};
    endfunction

    function comp_word_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
      logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] d1, d2, tv1, tv2, fine, centi, v1, v2, p, ps, mn, md, q;
      comp_word_t w;
      t1 = {48'd0, cal[bsc_pkg::RegTemp][15:0]};
      t2 = s16(cal[bsc_pkg::RegTemp], 16); t3 = s16(cal[bsc_pkg::RegTemp], 32);
      p1 = {48'd0, cal[bsc_pkg::RegPressA][15:0]};
      p2 = s16(cal[bsc_pkg::RegPressA], 16); p3 = s16(cal[bsc_pkg::RegPressA], 32);
      p4 = s16(cal[bsc_pkg::RegPressB], 0); p5 = s16(cal[bsc_pkg::RegPressB], 16);
      p6 = s16(cal[bsc_pkg::RegPressB], 32); p7 = s16(cal[bsc_pkg::RegPressC], 0);
      p8 = s16(cal[bsc_pkg::RegPressC], 16); p9 = s16(cal[bsc_pkg::RegPressC], 32);
      d1 = $signed({44'd0, adc_t >> 3}) - (t1 <<< 1);
      tv1 = (d1 * t2) >>> 11;
      d2 = $signed({44'd0, adc_t >> 4}) - t1;
      tv2 = (((d2 * d2) >>> 12) * t3) >>> 14;
      fine = tv1 + tv2;
      fine = {{32{fine[31]}}, fine[31:0]};
      centi = (fine * 5 + 128) >>> 8;
      w.fine = fine[31:0];
      w.centi = centi[31:0];
      w.press = '0;
      w.invalid = 1'b0;
      if (adc_p == bsc_pkg::SkipMark) begin
        w.invalid = 1'b1;
      end else begin
        v1 = fine - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        if (v1 == 0) begin
          w.invalid = 1'b1;
        end else begin
          p = 64'sd1048576 - $signed({44'd0, adc_p});
          p = ((p <<< 31) - v2) * 3125;
          // Truncating divide on magnitudes, wrapping like the hardware
          mn = p[63] ? -p : p;
          md = v1[63] ? -v1 : v1;
          q = $signed($unsigned(mn) / $unsigned(md));
          p = (p[63] != v1[63]) ? -q : q;
          ps = p >>> 13;
          v1 = (p9 * ps * ps) >>> 25;
          v2 = (p8 * p) >>> 19;
          p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
          if (p[63]) w.press = '0;
          else if (p[62:32] != 0) w.press = 32'hFFFF_FFFF;
          else w.press = p[31:0];
        end
      end
      return w;
    endfunction

    function void note_sample(logic [39:0] d);
      pending.push_back(compensate(d[19:0], d[39:20]));
    endfunction

    function void check_word(logic [95:0] d, logic u);
      comp_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.fine) begin
        $error("fine_temperature exp %0h got %0h", e.fine, d[31:0]); errors++;
      end
      if (d[63:32] !== e.centi) begin
        $error("temperature_centi exp %0h got %0h", e.centi, d[63:32]); errors++;
      end
      if (d[95:64] !== e.press) begin
        $error("pressure_q24_8 exp %0h got %0h", e.press, d[95:64]); errors++;
      end
      if (u !== e.invalid) begin
        $error("pressure_invalid exp %0b got %0b", e.invalid, u); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [39:0] s_axis_tdata;   // raw_temperature, raw_pressure
  logic [95:0] m_axis_tdata;   // fine_temperature, temperature_centi, pressure_q24_8
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [47:0] cfg_data_i;
  comp_scoreboard sb;
  int stall_mode;

  barometric_sensor_compensation_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("barometric_sensor_compensation_unit test failed");
    $finish;
  end

  // Check every accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser);
  end

  // Receiver stalls on its own pattern: free run, rare random stalls, or frequent random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 7) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic send_sample(logic [19:0] t, logic [19:0] p);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p, t};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample({p, t});
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(0, 6)) @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_cal(logic [1:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cal[idx] = val;
  endtask

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      2: return bsc_pkg::SkipMark;
      default: return 20'($urandom_range(20'h40000, 20'hA0000));
    endcase
  endfunction

  // Typical factory calibration, all-ones, all-zeros, mixed register extremes, or random values
  task automatic load_set(int k);
    case (k)
      0: begin
        write_cal(bsc_pkg::RegTemp, {16'hFC18, 16'h6AF3, 16'h6E9D});
        write_cal(bsc_pkg::RegPressA, {16'h0BD0, 16'hD6D0, 16'h8E4F});
        write_cal(bsc_pkg::RegPressB, {16'hFF32, 16'h0115, 16'h1C67});
        write_cal(bsc_pkg::RegPressC, {16'h1770, 16'hC4E0, 16'h000F});
      end
      1: for (int i = 0; i < 4; i++) write_cal(i[1:0], '1);
      2: for (int i = 0; i < 4; i++) write_cal(i[1:0], '0);
      3: begin
        write_cal(bsc_pkg::RegTemp, {16'h7FFF, 16'h8000, 16'hFFFF});
        write_cal(bsc_pkg::RegPressA, {16'h8000, 16'h7FFF, 16'hFFFF});
        write_cal(bsc_pkg::RegPressB, {16'h7FFF, 16'h8000, 16'h7FFF});
        write_cal(bsc_pkg::RegPressC, {16'h8000, 16'h7FFF, 16'h8000});
      end
      default: for (int i = 0; i < 4; i++) write_cal(i[1:0], 48'({$urandom, $urandom}));
    endcase
  endtask

  initial begin
    int left;
    sb = new();
    stall_mode = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = bsc_pkg::RegTemp;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset calibration (zero divisor), then a typical set with edge samples
    send_sample(20'h80000, 20'h50000);
    send_sample(20'h7E000, bsc_pkg::SkipMark);
    end_burst();
    drain();
    load_set(0);
    send_sample(20'h7E000, 20'h65000);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'hAAAAA, 20'h55555);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'h7E000, bsc_pkg::SkipMark);
    send_sample(20'h7E000, 20'h7FFFF);
    send_sample(20'h7E000, 20'h80001);
    end_burst();
    drain();

    // Random phases over several calibration sets
    for (int ph = 1; ph < 8; ph++) begin
      load_set(ph);
      for (int n = 0; n < 200; n += left) begin
        left = $urandom_range(1, 20);
        for (int j = 0; j < left; j++) send_sample(rand_raw(), rand_raw());
        end_burst();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("barometric_sensor_compensation_unit test passed");
    end else begin
      $display("barometric_sensor_compensation_unit test failed");
    end
    $finish;
  end
endmodule
